[sv/mso_pkg.sv]
// Shared types and constants for the marquee scroll offset block.
package mso_pkg;

  localparam int IDENT_W    = 64;
  localparam int TIME_W     = 32;
  localparam int GAP_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_W      = 5;   // counts the 32 steps of one divide pass
  localparam int VIEWPORT_RESET = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEWPORT = 2'd0,
    CFG_PAUSE    = 2'd1,
    CFG_STEP     = 2'd2,
    CFG_GAP      = 2'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_LOADM = 5'b00100,
    ST_MOD   = 5'b01000,
    ST_FIN   = 5'b10000
  } ctrl_state_e;

  typedef struct packed {
    logic accept;    // take the query, update identity, load the divider
    logic div_step;  // one shift-subtract step
    logic mod_load;  // reload the divider for the modulo pass
    logic capture;   // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic active;    // query needs the divide and modulo passes
  } dp_status_t;

endpackage

[sv/mso_intf.sv]
// Channel interfaces: query input, offset output and register writes.
interface mso_in_if #(
  parameter int PIXEL_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic [mso_pkg::IDENT_W-1:0]  text_tag;
  logic [PIXEL_BITS-1:0]        text_px;
  logic [mso_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, text_tag, text_px, now_ms, input ready);
  modport sink (input valid, text_tag, text_px, now_ms, output ready);
  modport monitor (input valid, ready, text_tag, text_px, now_ms);
endinterface

interface mso_out_if #(
  parameter int PIXEL_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [PIXEL_BITS:0] offset;

  modport source (output valid, offset, input ready);
  modport sink (input valid, offset, output ready);
  modport monitor (input valid, ready, offset);
endinterface

interface mso_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mso_pkg::CFG_IDX_W-1:0]  index;
  logic [mso_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

[sv/mso_ctrl.sv]
// Controller: sequences accept, divide pass, modulo pass and result hand-off.
module mso_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mso_pkg::dp_status_t status_i,
  output mso_pkg::dp_cmd_t    cmd_o
);

  mso_pkg::ctrl_state_e state_q, state_d;
  logic [mso_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic last_step;
  logic out_free;

  assign last_step = (cnt_q == '1);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      mso_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          state_d      = status_i.active ? mso_pkg::ST_DIV : mso_pkg::ST_FIN;
        end
      end
      mso_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (last_step) state_d = mso_pkg::ST_LOADM;
      end
      mso_pkg::ST_LOADM: begin
        cmd_o.mod_load = 1'b1;
        cnt_d          = '0;
        state_d        = mso_pkg::ST_MOD;
      end
      mso_pkg::ST_MOD: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (last_step) state_d = mso_pkg::ST_FIN;
      end
      mso_pkg::ST_FIN: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd_o.capture = 1'b1;
          state_d       = mso_pkg::ST_IDLE;
        end
      end
      default: state_d = mso_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.capture ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mso_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == mso_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[sv/mso_dp.sv]
// Datapath: registers, identity tracking and a shared shift-subtract divider.
module mso_dp #(
  parameter int PIXEL_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mso_pkg::IDENT_W-1:0]    text_tag_i,
  input  logic [PIXEL_BITS-1:0]          text_px_i,
  input  logic [mso_pkg::TIME_W-1:0]     now_ms_i,
  input  logic                           cfg_write_i,
  input  logic [mso_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mso_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  mso_pkg::dp_cmd_t               cmd_i,
  output mso_pkg::dp_status_t            status_o,
  output logic [PIXEL_BITS:0]            offset_o
);

  localparam int TW     = mso_pkg::TIME_W;
  localparam int LOOP_W = ((PIXEL_BITS > mso_pkg::GAP_W - 1) ?
                           PIXEL_BITS : mso_pkg::GAP_W - 1) + 1;

  // configuration
  logic [PIXEL_BITS-1:0]         viewport_q;
  logic [TW-1:0]                 pause_q;
  logic [TW-1:0]                 step_q;
  logic [mso_pkg::GAP_W-1:0]     gap_q;

  // query state
  logic                          seen_q;
  logic [mso_pkg::IDENT_W-1:0]   ident_q;
  logic [TW-1:0]                 start_q;

  // divider
  logic [TW-1:0]                 rem_q, quo_q, div_q;
  logic [LOOP_W-1:0]             loop_q;
  logic                          active_q;
  logic [PIXEL_BITS:0]           offset_q;

  logic                          new_ident;
  logic [TW-1:0]                 start_eff, elapsed;
  logic [LOOP_W-1:0]             gap_pos, loop_calc;
  logic [TW:0]                   shifted, diff;
  logic                          active;

  assign new_ident = !seen_q || (ident_q != text_tag_i);
  assign start_eff = new_ident ? now_ms_i : start_q;
  assign elapsed   = now_ms_i - start_eff;

  // negative gap acts as zero
  assign gap_pos   = gap_q[mso_pkg::GAP_W-1] ? '0 :
                     LOOP_W'(gap_q[mso_pkg::GAP_W-2:0]);
  assign loop_calc = LOOP_W'(text_px_i) + gap_pos;

  assign active = (text_px_i > viewport_q) && (step_q != '0) &&
                  (elapsed >= pause_q) && (loop_calc != '0);
  assign status_o.active = active;

  assign shifted = {rem_q, quo_q[TW-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      viewport_q <= PIXEL_BITS'(mso_pkg::VIEWPORT_RESET);
      pause_q    <= '0;
      step_q     <= '0;
      gap_q      <= '0;
      seen_q     <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        unique case (mso_pkg::cfg_reg_e'(cfg_index_i))
          mso_pkg::CFG_VIEWPORT: viewport_q <= cfg_data_i[PIXEL_BITS-1:0];
          mso_pkg::CFG_PAUSE:    pause_q    <= cfg_data_i[TW-1:0];
          mso_pkg::CFG_STEP:     step_q     <= cfg_data_i[TW-1:0];
          mso_pkg::CFG_GAP:      gap_q      <= cfg_data_i[mso_pkg::GAP_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) seen_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ident_q  <= text_tag_i;
      start_q  <= start_eff;
      quo_q    <= elapsed - pause_q;
      rem_q    <= '0;
      div_q    <= step_q;
      loop_q   <= loop_calc;
      active_q <= active;
    end
    if (cmd_i.div_step) begin
      if (!diff[TW]) begin
        rem_q <= diff[TW-1:0];
        quo_q <= {quo_q[TW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[TW-1:0];
        quo_q <= {quo_q[TW-2:0], 1'b0};
      end
    end
    // quotient stays in quo_q as the dividend of the modulo pass
    if (cmd_i.mod_load) begin
      rem_q <= '0;
      div_q <= TW'(loop_q);
    end
    if (cmd_i.capture) begin
      offset_q <= active_q ? rem_q[PIXEL_BITS:0] : '0;
    end
  end

  assign offset_o = offset_q;

endmodule

[sv/marquee_scroll_offset_top.sv]
// Top level of the marquee scroll offset block.
// Channels:
//   in_if  : one query per transfer - text tag, text width, time in ms.
//   out_if : one scroll offset per query, in query order.
//   cfg_if : register writes (viewport width, pause, step period, gap);
//            always ready, write only while no query is in flight.
// Sequencing:
//   A query that does not scroll (text fits, step period zero, still in the
//   pause) goes from its transfer straight to the output register load. A
//   scrolling query steps through taking the query, dividing the time past
//   the pause by the step period, reloading the divider, the quotient modulo
//   text width plus gap, and loading the output register. Both passes share
//   one shift-subtract divider and one query is in work at a time, so a new
//   query is taken only after the last one has loaded the output register.
// Stall: a finished offset waits in the output register while the next
//   query is worked; when that one is ready too, hold it and take no further
//   query until the receiver frees the register.
// Reset: registers return to their defaults (viewport 64, rest zero) and no
//   text is recorded, so the first query starts the timing afresh.
module marquee_scroll_offset_top #(
  parameter int PIXEL_BITS = 12
) (
  input logic         clk_i,
  input logic         rst_ni,
  mso_in_if.sink      in_if,
  mso_out_if.source   out_if,
  mso_cfg_if.sink     cfg_if
);

  mso_pkg::dp_cmd_t    cmd;
  mso_pkg::dp_status_t status;
  logic                in_ready;
  logic                out_valid;

  // register writes never stall
  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

  mso_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mso_dp #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_tag_i  (in_if.text_tag),
    .text_px_i   (in_if.text_px),
    .now_ms_i    (in_if.now_ms),
    .cfg_write_i (cfg_if.valid),
    .cfg_index_i (cfg_if.index),
    .cfg_data_i  (cfg_if.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .offset_o    (out_if.offset)
  );

endmodule

[sv/mso_checker.sv]
// Port-level checks for the marquee scroll offset block, bound to the top.
module mso_checker #(
  parameter int PIXEL_BITS = 12
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [PIXEL_BITS:0] out_offset_i,
  input logic                cfg_valid_i,
  input logic                cfg_ready_i
);

  // the block is not ready again in the cycle after it takes a query
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("query accepted back to back");

  // register writes are never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("register write stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("offset dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_offset_i))
    else $error("offset changed while stalled");

endmodule

bind marquee_scroll_offset_top mso_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_mso_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_offset_i (out_if.offset),
  .cfg_valid_i  (cfg_if.valid),
  .cfg_ready_i  (cfg_if.ready)
);
